>>> sv/sqpc_pkg.sv
// Shared constants, phase codes and arctangent table for the square waypoint controller.
`timescale 1ns / 1ps

package sqpc_pkg;

    localparam logic [1:0] PH_TURN    = 2'd0;
    localparam logic [1:0] PH_DRIVE   = 2'd1;
    localparam logic [1:0] PH_ADVANCE = 2'd2;

    localparam logic [2:0] REG_SPEED_LIMIT  = 3'd0;
    localparam logic [2:0] REG_LINEAR_GAIN  = 3'd1;
    localparam logic [2:0] REG_HEADING_GAIN = 3'd2;
    localparam logic [2:0] REG_TURN_GAIN    = 3'd3;
    localparam logic [2:0] REG_DIST_TOL     = 3'd4;
    localparam logic [2:0] REG_HEADING_TOL  = 3'd5;
    localparam logic [2:0] REG_TURN_TOL     = 3'd6;
    localparam logic [2:0] REG_SIDE_LENGTH  = 3'd7;

    localparam logic signed [18:0] PI_Q13      = 19'sd25736;
    localparam logic signed [18:0] TWO_PI_Q13  = 19'sd51472;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic [17:0]        VEL_MAX     = 18'd131072;

    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        logic [30:0] v;
        unique case (idx)
            5'd0:  v = 31'd843314856;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043836;
            5'd3:  v = 31'd133525158;
            5'd4:  v = 31'd67021686;
            5'd5:  v = 31'd33543515;
            5'd6:  v = 31'd16775850;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194282;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048575;
            5'd11: v = 31'd524287;
            5'd12: v = 31'd262143;
            5'd13: v = 31'd131071;
            5'd14: v = 31'd65535;
            5'd15: v = 31'd32767;
            5'd16: v = 31'd16383;
            5'd17: v = 31'd8191;
            5'd18: v = 31'd4095;
            5'd19: v = 31'd2047;
            5'd20: v = 31'd1023;
            5'd21: v = 31'd511;
            5'd22: v = 31'd255;
            5'd23: v = 31'd127;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/sqpc_isqrt.sv
// Bit-pair iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module sqpc_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= radicand;
            res_reg <= 64'd0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

>>> sv/sqpc_cordic.sv
// Iterative vectoring CORDIC giving atan2 in Q5.13 radians.
`timescale 1ns / 1ps

module sqpc_cordic
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] x_in,
    input  logic signed [32:0] y_in,
    output logic               done,
    output logic signed [17:0] angle
);

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic               busy_reg;
    logic               done_reg;
    logic [CW-1:0]      step_reg;
    logic signed [35:0] x_reg;
    logic signed [35:0] y_reg;
    logic signed [35:0] z_reg;
    logic signed [35:0] xs;
    logic signed [35:0] ys;
    logic signed [35:0] rot;
    logic signed [35:0] z_round;

    assign xs  = x_reg >>> step_reg;
    assign ys  = y_reg >>> step_reg;
    assign rot = $signed({5'b0, sqpc_pkg::atan_q30(5'(step_reg))});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == CW'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (x_in < 0)
            begin
                x_reg <= -36'(x_in);
                y_reg <= -36'(y_in);
                z_reg <= (y_in >= 0) ? sqpc_pkg::PI_Q30 : -sqpc_pkg::PI_Q30;
            end
            else
            begin
                x_reg <= 36'(x_in);
                y_reg <= 36'(y_in);
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + rot;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - rot;
            end
        end
    end

    assign z_round = (z_reg + 36'sd65536) >>> 17;
    assign done    = done_reg;
    assign angle   = 18'(z_round);

endmodule

>>> sv/square_waypoint_p_controller.sv
// Top level: sequencer, shared multiplier and registers of the square waypoint controller.
// Square waypoint proportional controller.
// Input channel (in_valid/in_ready): one pose word per control tick. The first
// word latches the origin. Output channel (out_valid/out_ready): command words,
// one per tick while a phase runs, two (back burst, then zero) when a phase ends,
// none on a corner advance tick or when speed_limit is zero. last marks the
// final word of a tick. Configuration channel (cfg_valid/cfg_ready) is always ready;
// registers are to be written by the user only while the block is idle (unenforced).
// A drive tick uses the 32-step square root unit and, while driving, the CORDIC
// rotations; all products go through one shared 32x32 multiplier.
// The second word of a finishing tick is offered in the cycle after the first is taken.
// in_ready is high only while the sequencer is idle, so one pose is worked on
// at a time; an advance tick leaves it high again on the next cycle.
// A stalled receiver holds the output register; the second word of a tick waits
// in the sequencer until the first is taken. The next pose may be accepted
// while the final word of the previous one is still waiting.
// Reset: configuration to defaults, origin unlatched, corner 0, turn phase.
`timescale 1ns / 1ps

module square_waypoint_p_controller
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] x_position,
    input  logic signed [31:0] y_position,
    input  logic signed [15:0] heading,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [18:0] linear_velocity,
    output logic signed [18:0] angular_velocity,
    output logic [1:0]         corner_index,
    output logic               phase_done,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [21:0]        cfg_data
);

    typedef enum logic [13:0]
    {
        S_IDLE  = 14'b00000000000001,
        S_PREP  = 14'b00000000000010,
        S_PMUL  = 14'b00000000000100,
        S_PRES  = 14'b00000000001000,
        S_SQX   = 14'b00000000010000,
        S_SQY   = 14'b00000000100000,
        S_SUM   = 14'b00000001000000,
        S_SQRT  = 14'b00000010000000,
        S_LMUL  = 14'b00000100000000,
        S_LRES  = 14'b00001000000000,
        S_CORD  = 14'b00010000000000,
        S_BURST = 14'b00100000000000,
        S_BRES  = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } state_t;

    function automatic logic signed [15:0] wrap_q13(input logic signed [17:0] d);
        logic signed [18:0] r;
        r = 19'(d) + sqpc_pkg::PI_Q13;
        if (r < 0)
        begin
            r = r + sqpc_pkg::TWO_PI_Q13;
        end
        else if (r >= sqpc_pkg::TWO_PI_Q13)
        begin
            r = r - sqpc_pkg::TWO_PI_Q13;
        end
        return 16'(r - sqpc_pkg::PI_Q13);
    endfunction

    function automatic logic [17:0] clamp_spd(input logic [63:0] v, input logic [17:0] lim);
        return (v > {46'b0, lim}) ? lim : v[17:0];
    endfunction

    function automatic logic signed [18:0] signed_mag(input logic [17:0] m, input logic neg);
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    function automatic logic signed [32:0] sat31(input logic signed [33:0] d);
        logic signed [32:0] r;
        if (d > 34'sd2147483648)
        begin
            r = 33'sd2147483648;
        end
        else if (d < -34'sd2147483648)
        begin
            r = -33'sd2147483648;
        end
        else
        begin
            r = 33'(d);
        end
        return r;
    endfunction

    // configuration
    logic [17:0] speed_limit_reg;
    logic [15:0] linear_gain_reg;
    logic [15:0] heading_gain_reg;
    logic [15:0] turn_gain_reg;
    logic [15:0] dist_tol_reg;
    logic [14:0] heading_tol_reg;
    logic [14:0] turn_tol_reg;
    logic [21:0] side_reg;

    state_t state_reg, state_next;

    logic               origin_valid_reg, origin_valid_next;
    logic signed [31:0] origin_x_reg, origin_x_next;
    logic signed [31:0] origin_y_reg, origin_y_next;
    logic signed [15:0] origin_h_reg, origin_h_next;
    logic [1:0]         corner_reg, corner_next;
    logic [1:0]         phase_reg, phase_next;
    logic signed [18:0] prev_lin_reg, prev_lin_next;
    logic signed [18:0] prev_ang_reg, prev_ang_next;
    logic               out_valid_reg, out_valid_next;

    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [15:0] h_reg, h_next;
    logic [15:0]        err_mag_reg, err_mag_next;
    logic               err_neg_reg, err_neg_next;
    logic signed [32:0] dx_reg, dx_next;
    logic signed [32:0] dy_reg, dy_next;
    logic [31:0]        ax_reg, ax_next;
    logic [31:0]        ay_reg, ay_next;
    logic [63:0]        sum_reg, sum_next;
    logic [63:0]        prod_reg;
    logic [31:0]        dist_reg, dist_next;
    logic [17:0]        v_reg, v_next;
    logic signed [18:0] res_lin_reg, res_lin_next;
    logic signed [18:0] res_ang_reg, res_ang_next;
    logic               res_done_reg, res_done_next;
    logic               res_last_reg, res_last_next;
    logic signed [18:0] out_lin_reg, out_lin_next;
    logic signed [18:0] out_ang_reg, out_ang_next;
    logic [1:0]         out_corner_reg, out_corner_next;
    logic               out_done_reg, out_done_next;
    logic               out_last_reg, out_last_next;

    logic [17:0]        spd;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic signed [17:0] corner_off;
    logic signed [15:0] goal_yaw;
    logic signed [15:0] turn_err;
    logic signed [15:0] drive_err;
    logic [15:0]        turn_mag;
    logic [15:0]        drive_mag;
    logic signed [33:0] side_s;
    logic signed [33:0] gx;
    logic signed [33:0] gy;
    logic signed [32:0] dx_sat;
    logic signed [32:0] dy_sat;
    logic signed [18:0] prev_sel;
    logic [17:0]        prev_mag;
    logic [17:0]        pmag;
    logic [17:0]        lin_mag;
    logic signed [18:0] pcmd;
    logic               out_load;

    logic               sqrt_start;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic               cord_start;
    logic               cord_done;
    logic signed [17:0] cord_angle;

    assign spd = (speed_limit_reg > sqpc_pkg::VEL_MAX) ? sqpc_pkg::VEL_MAX : speed_limit_reg;

    always_comb
    begin
        unique case (corner_reg)
            2'd0: corner_off = 18'sd0;
            2'd1: corner_off = sqpc_pkg::HALF_PI_Q13;
            2'd2: corner_off = 18'(sqpc_pkg::HALF_PI_Q13 * 2);
            2'd3: corner_off = 18'(sqpc_pkg::HALF_PI_Q13 * 3);
            default: corner_off = 18'sd0;
        endcase
    end

    assign goal_yaw  = wrap_q13(18'(origin_h_reg) + corner_off);
    assign turn_err  = wrap_q13(18'(goal_yaw) - 18'(h_reg));
    assign turn_mag  = turn_err[15] ? 16'(-turn_err) : 16'(turn_err);
    assign drive_err = wrap_q13(cord_angle - 18'(h_reg));
    assign drive_mag = drive_err[15] ? 16'(-drive_err) : 16'(drive_err);

    assign side_s = $signed({12'b0, side_reg});
    assign gx     = 34'(origin_x_reg) + ((corner_reg == 2'd0 || corner_reg == 2'd1) ? side_s : '0);
    assign gy     = 34'(origin_y_reg) + ((corner_reg == 2'd1 || corner_reg == 2'd2) ? side_s : '0);
    assign dx_sat = sat31(gx - 34'(x_reg));
    assign dy_sat = sat31(gy - 34'(y_reg));

    assign prev_sel = (phase_reg == sqpc_pkg::PH_TURN) ? prev_ang_reg : prev_lin_reg;
    assign prev_mag = prev_sel[18] ? 18'(-prev_sel) : 18'(prev_sel);
    assign pmag     = clamp_spd(prod_reg >> 5, spd);
    assign lin_mag  = clamp_spd(prod_reg >> 8, spd);
    assign pcmd     = signed_mag(pmag, err_neg_reg);

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_PMUL:
            begin
                mul_a = {16'b0, err_mag_reg};
                mul_b = {16'b0, (phase_reg == sqpc_pkg::PH_TURN) ? turn_gain_reg
                                                                : heading_gain_reg};
            end
            S_SQX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            S_SQY:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            S_LMUL:
            begin
                mul_a = dist_reg;
                mul_b = {16'b0, linear_gain_reg};
            end
            S_BURST:
            begin
                mul_a = {14'b0, prev_mag};
                mul_b = {16'b0, (phase_reg == sqpc_pkg::PH_TURN) ? turn_gain_reg
                                                                : linear_gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign out_load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next        = state_reg;
        origin_valid_next = origin_valid_reg;
        origin_x_next     = origin_x_reg;
        origin_y_next     = origin_y_reg;
        origin_h_next     = origin_h_reg;
        corner_next       = corner_reg;
        phase_next        = phase_reg;
        prev_lin_next     = prev_lin_reg;
        prev_ang_next     = prev_ang_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        h_next            = h_reg;
        err_mag_next      = err_mag_reg;
        err_neg_next      = err_neg_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        ax_next           = ax_reg;
        ay_next           = ay_reg;
        sum_next          = sum_reg;
        dist_next         = dist_reg;
        v_next            = v_reg;
        res_lin_next      = res_lin_reg;
        res_ang_next      = res_ang_reg;
        res_done_next     = res_done_reg;
        res_last_next     = res_last_reg;
        out_lin_next      = out_lin_reg;
        out_ang_next      = out_ang_reg;
        out_corner_next   = out_corner_reg;
        out_done_next     = out_done_reg;
        out_last_next     = out_last_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        sqrt_start        = 1'b0;
        cord_start        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next = x_position;
                    y_next = y_position;
                    h_next = heading;
                    if (!origin_valid_reg)
                    begin
                        origin_valid_next = 1'b1;
                        origin_x_next     = x_position;
                        origin_y_next     = y_position;
                        origin_h_next     = heading;
                    end
                    if (spd != '0)
                    begin
                        if (phase_reg == sqpc_pkg::PH_TURN || phase_reg == sqpc_pkg::PH_DRIVE)
                        begin
                            state_next = S_PREP;
                        end
                        else
                        begin
                            corner_next = corner_reg + 2'd1;
                            phase_next  = sqpc_pkg::PH_TURN;
                        end
                    end
                end
            end
            S_PREP:
            begin
                if (phase_reg == sqpc_pkg::PH_TURN)
                begin
                    err_mag_next = turn_mag;
                    err_neg_next = turn_err[15];
                    state_next   = (turn_mag <= {1'b0, turn_tol_reg}) ? S_BURST : S_PMUL;
                end
                else
                begin
                    dx_next    = dx_sat;
                    dy_next    = dy_sat;
                    ax_next    = dx_sat[32] ? 32'(-dx_sat) : 32'(dx_sat);
                    ay_next    = dy_sat[32] ? 32'(-dy_sat) : 32'(dy_sat);
                    state_next = S_SQX;
                end
            end
            S_PMUL:
            begin
                state_next = S_PRES;
            end
            S_PRES:
            begin
                if (phase_reg == sqpc_pkg::PH_TURN)
                begin
                    if (pmag == '0)
                    begin
                        state_next = S_BURST;
                    end
                    else
                    begin
                        res_lin_next  = '0;
                        res_ang_next  = pcmd;
                        res_done_next = 1'b0;
                        res_last_next = 1'b1;
                        prev_lin_next = '0;
                        prev_ang_next = pcmd;
                        state_next    = S_EMIT;
                    end
                end
                else
                begin
                    res_lin_next  = $signed({1'b0, v_reg});
                    res_ang_next  = pcmd;
                    res_done_next = 1'b0;
                    res_last_next = 1'b1;
                    prev_lin_next = $signed({1'b0, v_reg});
                    prev_ang_next = pcmd;
                    state_next    = S_EMIT;
                end
            end
            S_SQX:
            begin
                state_next = S_SQY;
            end
            S_SQY:
            begin
                sum_next   = prod_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sqrt_start = 1'b1;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    dist_next  = sqrt_root;
                    state_next = S_LMUL;
                end
            end
            S_LMUL:
            begin
                state_next = S_LRES;
            end
            S_LRES:
            begin
                if (dist_reg > {16'b0, dist_tol_reg} && lin_mag != '0)
                begin
                    v_next     = lin_mag;
                    cord_start = 1'b1;
                    state_next = S_CORD;
                end
                else
                begin
                    state_next = S_BURST;
                end
            end
            S_CORD:
            begin
                if (cord_done)
                begin
                    err_mag_next = drive_mag;
                    err_neg_next = drive_err[15];
                    if (drive_mag <= {1'b0, heading_tol_reg})
                    begin
                        res_lin_next  = $signed({1'b0, v_reg});
                        res_ang_next  = '0;
                        res_done_next = 1'b0;
                        res_last_next = 1'b1;
                        prev_lin_next = $signed({1'b0, v_reg});
                        prev_ang_next = '0;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_PMUL;
                    end
                end
            end
            S_BURST:
            begin
                state_next = S_BRES;
            end
            S_BRES:
            begin
                // burst opposes the last command on the phase's own axis
                if (phase_reg == sqpc_pkg::PH_TURN)
                begin
                    res_lin_next = '0;
                    res_ang_next = signed_mag(lin_mag, !prev_sel[18]);
                    phase_next   = sqpc_pkg::PH_DRIVE;
                end
                else
                begin
                    res_lin_next = signed_mag(lin_mag, !prev_sel[18]);
                    res_ang_next = '0;
                    phase_next   = sqpc_pkg::PH_ADVANCE;
                end
                res_done_next = 1'b1;
                res_last_next = 1'b0;
                prev_lin_next = '0;
                prev_ang_next = '0;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_lin_next    = res_lin_reg;
                    out_ang_next    = res_ang_reg;
                    out_corner_next = corner_reg;
                    out_done_next   = res_done_reg;
                    out_last_next   = res_last_reg;
                    if (res_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        res_lin_next  = '0;
                        res_ang_next  = '0;
                        res_last_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg  <= 18'd13107;
            linear_gain_reg  <= 16'd256;
            heading_gain_reg <= 16'd256;
            turn_gain_reg    <= 16'd256;
            dist_tol_reg     <= 16'd3277;
            heading_tol_reg  <= 15'd82;
            turn_tol_reg     <= 15'd82;
            side_reg         <= 22'd327680;
            state_reg        <= S_IDLE;
            origin_valid_reg <= 1'b0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            origin_h_reg     <= '0;
            corner_reg       <= '0;
            phase_reg        <= sqpc_pkg::PH_TURN;
            prev_lin_reg     <= '0;
            prev_ang_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    sqpc_pkg::REG_SPEED_LIMIT:  speed_limit_reg  <= cfg_data[17:0];
                    sqpc_pkg::REG_LINEAR_GAIN:  linear_gain_reg  <= cfg_data[15:0];
                    sqpc_pkg::REG_HEADING_GAIN: heading_gain_reg <= cfg_data[15:0];
                    sqpc_pkg::REG_TURN_GAIN:    turn_gain_reg    <= cfg_data[15:0];
                    sqpc_pkg::REG_DIST_TOL:     dist_tol_reg     <= cfg_data[15:0];
                    sqpc_pkg::REG_HEADING_TOL:  heading_tol_reg  <= cfg_data[14:0];
                    sqpc_pkg::REG_TURN_TOL:     turn_tol_reg     <= cfg_data[14:0];
                    sqpc_pkg::REG_SIDE_LENGTH:  side_reg         <= cfg_data;
                    default:                    side_reg         <= side_reg;
                endcase
            end
            state_reg        <= state_next;
            origin_valid_reg <= origin_valid_next;
            origin_x_reg     <= origin_x_next;
            origin_y_reg     <= origin_y_next;
            origin_h_reg     <= origin_h_next;
            corner_reg       <= corner_next;
            phase_reg        <= phase_next;
            prev_lin_reg     <= prev_lin_next;
            prev_ang_reg     <= prev_ang_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        h_reg          <= h_next;
        err_mag_reg    <= err_mag_next;
        err_neg_reg    <= err_neg_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        ax_reg         <= ax_next;
        ay_reg         <= ay_next;
        sum_reg        <= sum_next;
        prod_reg       <= {32'b0, mul_a} * {32'b0, mul_b};
        dist_reg       <= dist_next;
        v_reg          <= v_next;
        res_lin_reg    <= res_lin_next;
        res_ang_reg    <= res_ang_next;
        res_done_reg   <= res_done_next;
        res_last_reg   <= res_last_next;
        out_lin_reg    <= out_lin_next;
        out_ang_reg    <= out_ang_next;
        out_corner_reg <= out_corner_next;
        out_done_reg   <= out_done_next;
        out_last_reg   <= out_last_next;
    end

    sqpc_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg + prod_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    sqpc_cordic
    #(
        .CORDIC_STEPS (CORDIC_STEPS)
    )
    u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .x_in  (dx_reg),
        .y_in  (dy_reg),
        .done  (cord_done),
        .angle (cord_angle)
    );

    assign in_ready         = (state_reg == S_IDLE);
    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign linear_velocity  = out_lin_reg;
    assign angular_velocity = out_ang_reg;
    assign corner_index     = out_corner_reg;
    assign phase_done       = out_done_reg;
    assign last             = out_last_reg;

endmodule
